### sv/ierp_pkg.sv
`default_nettype none

package ierp_pkg;

  // longest packet prefix that is counted and recorded
  localparam int MAX_PACKET_BYTES = 4096;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PORT_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_HIGH = 1'd1;

  localparam logic [15:0] PORT_LOW_RESET  = 16'd33434;
  localparam logic [16:0] PORT_HIGH_RESET = 17'd33534;

  localparam logic [7:0] ICMP_DEST_UNREACH     = 8'd3;
  localparam logic [7:0] ICMP_CODE_PORT_UNREACH = 8'd3;
  localparam logic [7:0] ICMP_TIME_EXCEEDED    = 8'd11;
  localparam logic [7:0] ICMP_CODE_TTL_EXCEEDED = 8'd0;
  localparam logic [7:0] IP_PROTO_UDP          = 8'h11;

  // byte offsets inside an ipv4 header and after the icmp header
  localparam int ICMP_HDR_BYTES = 8;
  localparam int UDP_HDR_BYTES  = 8;
  localparam int IP_PROTO_OFS   = 9;
  localparam int IP_SRC_OFS     = 12;
  localparam int IP_DST_OFS     = 16;

  typedef enum logic [1:0] {
    KIND_NONE          = 2'd0,
    KIND_PORT_UNREACH  = 2'd1,
    KIND_TTL_EXCEEDED  = 2'd2
  } kind_e;

  typedef struct packed {
    logic        valid_res;
    kind_e       kind;
    logic [15:0] quoted_sport;
    logic [15:0] quoted_dport;
    logic [31:0] emitter_addr;
    logic [31:0] target_addr;
  } result_t;

endpackage

`default_nettype wire

### sv/ierp_if.sv
`default_nettype none

interface ierp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface ierp_out_if;
  logic                 valid;
  logic                 ready;
  logic                 valid_res;
  ierp_pkg::kind_e      kind;
  logic [15:0]          quoted_sport;
  logic [15:0]          quoted_dport;
  logic [31:0]          emitter_addr;
  logic [31:0]          target_addr;

  modport source (output valid, output valid_res, output kind, output quoted_sport,
                  output quoted_dport, output emitter_addr, output target_addr,
                  input ready);
  modport sink   (input valid, input valid_res, input kind, input quoted_sport,
                  input quoted_dport, input emitter_addr, input target_addr,
                  output ready);
endinterface

`default_nettype wire

### sv/icmp_error_reply_parser_top.sv
`default_nettype none

// channel   dir  payload                                          transfer
// in_if     in   packet_byte[7:0], last_byte                      valid & ready
// out_if    out  valid_res, kind[1:0], quoted_sport[15:0],        valid & ready
//                quoted_dport[15:0], emitter_addr[31:0], target_addr[31:0]
// cfg       in   cfg_idx_i[0], cfg_data_i[16:0]                   cfg_we_i
//
// one byte per clock sustained; a byte is registered on its transfer and
// updates the packet state as it leaves the input register, where a last byte
// also loads the output register, from which its result is shown
// the only stall source is the output register: a last byte waits in the input
// register while an earlier result is not yet taken, and no byte is taken meanwhile
// reset clears the packet state and loads the port window defaults, no sweep

module icmp_error_reply_parser_top (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  ierp_in_if.sink                              in_if,
  ierp_out_if.source                           out_if,
  input  wire                                  cfg_we_i,
  input  wire [ierp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire [ierp_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import ierp_pkg::*;

  // place byte b at slot k of a big-endian word
  function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] k, logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (k)
      2'd0:    r[31:24] = b;
      2'd1:    r[23:16] = b;
      2'd2:    r[15:8]  = b;
      default: r[7:0]   = b;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] port_low_q;
  logic [16:0] port_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_low_q  <= PORT_LOW_RESET;
      port_high_q <= PORT_HIGH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PORT_LOW:  port_low_q  <= cfg_data_i[15:0];
        CFG_PORT_HIGH: port_high_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       out_valid_q;
  result_t    res_q;
  logic       out_free;
  logic       s1_go;
  logic       in_xfer;

  // output slot is free if empty or being drained this cycle
  assign out_free   = !out_valid_q || out_if.ready;
  // a last byte needs the output slot, any other byte moves on at once
  assign s1_go      = s1_valid_q && (!s1_last_q || out_free);
  assign in_if.ready = !s1_valid_q || s1_go;
  assign in_xfer    = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= in_if.packet_byte;
      s1_last_q <= in_if.last_byte;
    end
  end

  // ---------------------------------------------------------------------
  // packet state and per-byte field capture
  // ---------------------------------------------------------------------
  logic [POS_W-1:0] pos_q,   pos_d;
  logic [5:0]       ohl_q,   ohl_d;
  logic [5:0]       ihl_q,   ihl_d;
  logic [15:0]      tc_q,    tc_d;
  logic [7:0]       proto_q, proto_d;
  logic [31:0]      ports_q, ports_d;
  logic [31:0]      osrc_q,  osrc_d;
  logic [31:0]      idst_q,  idst_d;

  logic [POS_W-1:0] ohl_w;
  logic [POS_W-1:0] inner_w;
  logic [POS_W-1:0] ihl_w;
  logic [POS_W-1:0] dst_ofs;
  logic [POS_W-1:0] port_ofs;
  logic [POS_W-1:0] port_base;

  always_comb begin
    pos_d   = pos_q;
    ohl_d   = ohl_q;
    ihl_d   = ihl_q;
    tc_d    = tc_q;
    proto_d = proto_q;
    ports_d = ports_q;
    osrc_d  = osrc_q;
    idst_d  = idst_q;

    // header length nibble of byte 0 counts 32-bit words
    if (pos_q == '0) begin
      ohl_d = {s1_byte_q[3:0], 2'b00};
    end
    ohl_w   = POS_W'(ohl_d);
    inner_w = ohl_w + POS_W'(ICMP_HDR_BYTES);
    if (pos_q == inner_w) begin
      ihl_d = {s1_byte_q[3:0], 2'b00};
    end
    ihl_w     = POS_W'(ihl_d);
    port_base = inner_w + ihl_w;
    dst_ofs   = pos_q - inner_w - POS_W'(IP_DST_OFS);
    port_ofs  = pos_q - port_base;

    if (pos_q < POS_W'(MAX_PACKET_BYTES)) begin
      // capture against the updated lengths, so a short header may overlap
      if (pos_q == ohl_w) begin
        tc_d[15:8] = s1_byte_q;
      end
      if (pos_q == ohl_w + POS_W'(1)) begin
        tc_d[7:0] = s1_byte_q;
      end
      if (pos_q >= POS_W'(IP_SRC_OFS) && pos_q < POS_W'(IP_SRC_OFS + 4)) begin
        osrc_d = put_byte(osrc_q, pos_q[1:0], s1_byte_q);
      end
      if (pos_q == inner_w + POS_W'(IP_PROTO_OFS)) begin
        proto_d = s1_byte_q;
      end
      if (pos_q >= inner_w + POS_W'(IP_DST_OFS) &&
          pos_q <  inner_w + POS_W'(IP_DST_OFS + 4)) begin
        idst_d = put_byte(idst_q, dst_ofs[1:0], s1_byte_q);
      end
      if (pos_q >= port_base && pos_q < port_base + POS_W'(4)) begin
        ports_d = put_byte(ports_q, port_ofs[1:0], s1_byte_q);
      end
    end else begin
      // saturated: lengths of byte zero are not re-read
      ohl_d = ohl_q;
      ihl_d = ihl_q;
    end

    if (pos_q < POS_W'(MAX_PACKET_BYTES)) begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ohl_q   <= '0;
      ihl_q   <= '0;
      tc_q    <= '0;
      proto_q <= '0;
      ports_q <= '0;
      osrc_q  <= '0;
      idst_q  <= '0;
    end else if (s1_go) begin
      if (s1_last_q) begin
        // next packet starts clean
        pos_q   <= '0;
        ohl_q   <= '0;
        ihl_q   <= '0;
        tc_q    <= '0;
        proto_q <= '0;
        ports_q <= '0;
        osrc_q  <= '0;
        idst_q  <= '0;
      end else begin
        pos_q   <= pos_d;
        ohl_q   <= ohl_d;
        ihl_q   <= ihl_d;
        tc_q    <= tc_d;
        proto_q <= proto_d;
        ports_q <= ports_d;
        osrc_q  <= osrc_d;
        idst_q  <= idst_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // result evaluation on the last byte
  // ---------------------------------------------------------------------
  result_t          res_d;
  logic [POS_W-1:0] need_bytes;
  logic             long_enough;
  logic [15:0]      quoted_dport;
  logic             in_window;

  assign need_bytes  = POS_W'(ohl_d) + POS_W'(ICMP_HDR_BYTES) + POS_W'(ihl_d)
                     + POS_W'(UDP_HDR_BYTES);
  assign long_enough = pos_d >= need_bytes;
  assign quoted_dport = ports_d[15:0];
  assign in_window   = (quoted_dport >= port_low_q) &&
                       ({1'b0, quoted_dport} < port_high_q);

  always_comb begin
    res_d = '0;
    if (long_enough) begin
      if (tc_d[15:8] == ICMP_DEST_UNREACH && tc_d[7:0] == ICMP_CODE_PORT_UNREACH) begin
        res_d.kind = KIND_PORT_UNREACH;
      end else if (tc_d[15:8] == ICMP_TIME_EXCEEDED &&
                   tc_d[7:0] == ICMP_CODE_TTL_EXCEEDED) begin
        res_d.kind = KIND_TTL_EXCEEDED;
      end
      if (res_d.kind != KIND_NONE && proto_d == IP_PROTO_UDP) begin
        res_d.quoted_dport = quoted_dport;
        if (in_window) begin
          res_d.valid_res    = 1'b1;
          res_d.quoted_sport = ports_d[31:16];
          res_d.emitter_addr = osrc_d;
          res_d.target_addr  = idst_d;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.valid_res    = res_q.valid_res;
  assign out_if.kind         = res_q.kind;
  assign out_if.quoted_sport = res_q.quoted_sport;
  assign out_if.quoted_dport = res_q.quoted_dport;
  assign out_if.emitter_addr = res_q.emitter_addr;
  assign out_if.target_addr  = res_q.target_addr;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_valid_has_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.valid_res |-> res_q.kind != KIND_NONE)
    else $error("valid result without a known kind");

  a_rejected_is_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.valid_res |->
      res_q.quoted_sport == '0 && res_q.emitter_addr == '0 && res_q.target_addr == '0)
    else $error("rejected result carries data");

  a_no_kind_no_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == KIND_NONE |-> res_q.quoted_dport == '0)
    else $error("port given without a kind");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_last_q |=> out_valid_q && pos_q == '0 && ohl_q == '0)
    else $error("last byte did not deliver a result or clear the packet");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_PACKET_BYTES))
    else $error("byte count beyond its limit");

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ierp_pkg::*;

  // run shape
  localparam int ITEM_GOAL       = 750;  // random bytes to send at least
  localparam int REPLY_GOAL      = 48;   // random packets, one reply each
  localparam int PKTS_PER_PHASE  = 8;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT  = 2000;

  // how a stimulus packet is laid out
  typedef enum {SHAPE_IP, SHAPE_FLAT_RANDOM, SHAPE_FLAT_ZERO, SHAPE_FLAT_ONES} shape_e;

  // receiver stall patterns
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

  // one packet of stimulus; for flat shapes extra is the whole length,
  // for ip shape it is added to the minimum length (negative gives a short packet)
  typedef struct {
    shape_e      shape;
    logic [3:0]  ohl_n;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [3:0]  ihl_n;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] saddr;
    logic [31:0] daddr;
    int          extra;
    bit          typed;
    result_t     want;
  } probe_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ierp_in_if  in_ch ();
  ierp_out_if out_ch ();

  icmp_error_reply_parser_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // replies still owed by the block, oldest first
  result_t reply_q[$];
  int      fail_cnt     = 0;
  int      quiet_cycles = 0;

  // bytes of the packet being sent
  logic [7:0] pkt_bytes[$];

  // sender pacing
  bit sender_bursty = 1'b1;
  int burst_left    = 0;

  // our copy of the port window
  logic [15:0] win_lo = PORT_LOW_RESET;
  logic [16:0] win_hi = PORT_HIGH_RESET;

  // parser state, cleared after every last byte
  int          rx_pos      = 0;
  logic [5:0]  hdr_len     = '0;
  logic [5:0]  quoted_len  = '0;
  logic [15:0] type_code   = '0;
  logic [7:0]  quoted_proto = '0;
  logic [31:0] udp_ports   = '0;
  logic [31:0] src_addr    = '0;
  logic [31:0] quoted_dst  = '0;

  // feed one byte to the parser copy; returns 1 with the reply on a last byte
  function automatic bit parse_byte(input logic [7:0] b, input bit last,
                                    output result_t res);
    int p, o, inr, ih;
    res = '0;
    p = rx_pos;
    // bytes past the saturation point are neither counted nor recorded
    if (p < MAX_PACKET_BYTES) begin
      if (p == 0) hdr_len = {b[3:0], 2'b00};
      o = int'(hdr_len);
      if (p >= IP_SRC_OFS && p < IP_SRC_OFS + 4)
        src_addr[8 * (3 - (p - IP_SRC_OFS)) +: 8] = b;
      if (p == o) type_code[15:8] = b;
      if (p == o + 1) type_code[7:0] = b;
      inr = o + ICMP_HDR_BYTES;
      if (p == inr) quoted_len = {b[3:0], 2'b00};
      ih = int'(quoted_len);
      if (p == inr + IP_PROTO_OFS) quoted_proto = b;
      if (p >= inr + IP_DST_OFS && p < inr + IP_DST_OFS + 4)
        quoted_dst[8 * (3 - (p - inr - IP_DST_OFS)) +: 8] = b;
      // header lengths below 20 let these regions overlap, as in the block
      if (p >= inr + ih && p < inr + ih + 4)
        udp_ports[8 * (3 - (p - inr - ih)) +: 8] = b;
      rx_pos = p + 1;
    end
    if (!last) return 1'b0;

    // short packets leave every field at zero
    if (rx_pos >= int'(hdr_len) + ICMP_HDR_BYTES + int'(quoted_len) + UDP_HDR_BYTES) begin
      if (type_code[15:8] == ICMP_DEST_UNREACH && type_code[7:0] == ICMP_CODE_PORT_UNREACH)
        res.kind = KIND_PORT_UNREACH;
      else if (type_code[15:8] == ICMP_TIME_EXCEEDED &&
               type_code[7:0] == ICMP_CODE_TTL_EXCEEDED)
        res.kind = KIND_TTL_EXCEEDED;
      if (res.kind != KIND_NONE && quoted_proto == IP_PROTO_UDP) begin
        res.quoted_dport = udp_ports[15:0];
        // an empty or inverted window takes no port
        if (res.quoted_dport >= win_lo && {1'b0, res.quoted_dport} < win_hi) begin
          res.valid_res    = 1'b1;
          res.quoted_sport = udp_ports[31:16];
          res.emitter_addr = src_addr;
          res.target_addr  = quoted_dst;
        end
      end
    end

    rx_pos       = 0;
    hdr_len      = '0;
    quoted_len   = '0;
    type_code    = '0;
    quoted_proto = '0;
    udp_ports    = '0;
    src_addr     = '0;
    quoted_dst   = '0;
    return 1'b1;
  endfunction

  function automatic probe_t probe_row(
    input shape_e shape, input logic [3:0] ohl_n, input logic [7:0] icmp_type,
    input logic [7:0] icmp_code, input logic [3:0] ihl_n, input logic [7:0] proto,
    input logic [15:0] sport, input logic [15:0] dport, input logic [31:0] saddr,
    input logic [31:0] daddr, input int extra, input bit typed, input result_t want);
    probe_t r;
    r.shape     = shape;
    r.ohl_n     = ohl_n;
    r.icmp_type = icmp_type;
    r.icmp_code = icmp_code;
    r.ihl_n     = ihl_n;
    r.proto     = proto;
    r.sport     = sport;
    r.dport     = dport;
    r.saddr     = saddr;
    r.daddr     = daddr;
    r.extra     = extra;
    r.typed     = typed;
    r.want      = want;
    return r;
  endfunction

  // mostly well formed replies with random content, some broken, some noise
  function automatic probe_t rand_probe();
    probe_t r;
    int     lo, hi;
    r = probe_row(SHAPE_IP, 4'd5, ICMP_DEST_UNREACH, ICMP_CODE_PORT_UNREACH, 4'd5,
                  IP_PROTO_UDP, 16'($urandom), 16'($urandom), $urandom, $urandom,
                  $urandom_range(4), 1'b0, '0);
    if ($urandom_range(9) == 0) begin
      r.shape = SHAPE_FLAT_RANDOM;
      r.extra = $urandom_range(1, 80);
      return r;
    end
    if ($urandom_range(9) < 3) r.ohl_n = 4'($urandom);
    if ($urandom_range(9) < 3) r.ihl_n = 4'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: ;
      4, 5, 6: begin
        r.icmp_type = ICMP_TIME_EXCEEDED;
        r.icmp_code = ICMP_CODE_TTL_EXCEEDED;
      end
      7: r.icmp_code = 8'($urandom);
      8: begin
        r.icmp_type = ICMP_TIME_EXCEEDED;
        r.icmp_code = 8'($urandom);
      end
      default: begin
        r.icmp_type = 8'($urandom);
        r.icmp_code = 8'($urandom);
      end
    endcase
    if ($urandom_range(9) == 0) r.proto = 8'($urandom);
    // aim the port at the window edges and inside it
    lo = int'(win_lo);
    hi = int'(win_hi);
    case ($urandom_range(6))
      0: r.dport = 16'(lo - 1);
      1: r.dport = 16'(lo);
      2: r.dport = 16'(hi - 1);
      3: r.dport = 16'(hi);
      4, 5: if (hi > lo) r.dport = 16'(lo + $urandom_range(hi - lo - 1));
      default: ;
    endcase
    case ($urandom_range(9))
      0, 1: r.extra = -$urandom_range(1, 12);
      2: r.extra = $urandom_range(5, 30);
      default: ;
    endcase
    return r;
  endfunction

  // write v at idx unless the packet is too short to hold it
  function automatic void place(input int idx, input logic [7:0] v);
    if (idx < pkt_bytes.size()) pkt_bytes[idx] = v;
  endfunction

  task automatic build_packet(input probe_t r);
    int o, inr, ih, len;
    pkt_bytes.delete();
    if (r.shape != SHAPE_IP) begin
      for (int i = 0; i < r.extra; i++) begin
        case (r.shape)
          SHAPE_FLAT_ZERO: pkt_bytes.push_back(8'h00);
          SHAPE_FLAT_ONES: pkt_bytes.push_back(8'hFF);
          default:         pkt_bytes.push_back(8'($urandom));
        endcase
      end
      return;
    end
    o   = int'(r.ohl_n) * 4;
    ih  = int'(r.ihl_n) * 4;
    inr = o + ICMP_HDR_BYTES;
    len = inr + ih + UDP_HDR_BYTES + r.extra;
    if (len < 1) len = 1;
    for (int i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom));
    // later fields win where small header lengths make them collide
    place(0, {4'h4, r.ohl_n});
    for (int k = 0; k < 4; k++) begin
      place(IP_SRC_OFS + k, r.saddr[8 * (3 - k) +: 8]);
    end
    place(o, r.icmp_type);
    place(o + 1, r.icmp_code);
    place(inr, {4'h4, r.ihl_n});
    place(inr + IP_PROTO_OFS, r.proto);
    for (int k = 0; k < 4; k++) begin
      place(inr + IP_DST_OFS + k, r.daddr[8 * (3 - k) +: 8]);
    end
    place(inr + ih, r.sport[15:8]);
    place(inr + ih + 1, r.sport[7:0]);
    place(inr + ih + 2, r.dport[15:8]);
    place(inr + ih + 3, r.dport[7:0]);
  endtask

  // bursts of random length with random gaps, or back to back
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (sender_bursty && $urandom_range(3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // send pkt_bytes; a typed row overrides the predicted reply
  task automatic send_packet(input bit typed, input result_t want);
    result_t res;
    int      n;
    n = pkt_bytes.size();
    for (int i = 0; i < n; i++) begin
      pace_sender();
      in_ch.valid       <= 1'b1;
      in_ch.packet_byte <= pkt_bytes[i];
      in_ch.last_byte   <= (i == n - 1);
      do @(posedge clk_i); while (in_ch.ready !== 1'b1);
      if (parse_byte(pkt_bytes[i], i == n - 1, res))
        reply_q.push_back(typed ? want : res);
    end
  endtask

  // stop sending and let every owed reply come out
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both window registers, one per cycle; only called with the block idle
  task automatic write_window(input logic [15:0] lo, input logic [16:0] hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PORT_LOW;
    cfg_data_i <= {1'b0, lo};
    @(posedge clk_i);
    win_lo = lo;
    cfg_idx_i  <= CFG_PORT_HIGH;
    cfg_data_i <= hi;
    @(posedge clk_i);
    win_hi = hi;
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    probe_t      tbl[$];
    int          phase, rand_pkts, rand_bytes, span;
    logic [15:0] lo;
    logic [16:0] hi;

    in_ch.valid       = 1'b0;
    in_ch.packet_byte = '0;
    in_ch.last_byte   = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_PORT_LOW;
    cfg_data_i        = '0;

    // directed rows, run with the reset window 33434..33533
    // first packet after reset: a single zero byte, far too short
    tbl.push_back(probe_row(SHAPE_FLAT_ZERO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1'b1, '0));
    // clean port unreachable at the low window edge
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_DEST_UNREACH, ICMP_CODE_PORT_UNREACH, 5,
      IP_PROTO_UDP, 16'hABCD, 16'd33434, 32'h0A000001, 32'hC0A80101, 0, 1'b1,
      '{1'b1, KIND_PORT_UNREACH, 16'hABCD, 16'd33434, 32'h0A000001, 32'hC0A80101}));
    // ttl exceeded at the top of the window, trailing bytes, extreme values
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_TIME_EXCEEDED, ICMP_CODE_TTL_EXCEEDED, 5,
      IP_PROTO_UDP, 16'hFFFF, 16'd33533, 32'hFFFFFFFF, 32'h00000001, 3, 1'b1,
      '{1'b1, KIND_TTL_EXCEEDED, 16'hFFFF, 16'd33533, 32'hFFFFFFFF, 32'h00000001}));
    // port just past the exclusive bound and just below the low bound
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_DEST_UNREACH, ICMP_CODE_PORT_UNREACH, 5,
      IP_PROTO_UDP, 16'h1234, 16'd33534, 32'h01020304, 32'h05060708, 0, 1'b1,
      '{1'b0, KIND_PORT_UNREACH, 16'h0, 16'd33534, 32'h0, 32'h0}));
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_DEST_UNREACH, ICMP_CODE_PORT_UNREACH, 5,
      IP_PROTO_UDP, 16'h1234, 16'd33433, 32'h01020304, 32'h05060708, 0, 1'b1,
      '{1'b0, KIND_PORT_UNREACH, 16'h0, 16'd33433, 32'h0, 32'h0}));
    // port field extremes
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_DEST_UNREACH, ICMP_CODE_PORT_UNREACH, 5,
      IP_PROTO_UDP, 16'h0000, 16'd0, 32'h0, 32'h0, 0, 1'b1,
      '{1'b0, KIND_PORT_UNREACH, 16'h0, 16'd0, 32'h0, 32'h0}));
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_TIME_EXCEEDED, ICMP_CODE_TTL_EXCEEDED, 5,
      IP_PROTO_UDP, 16'h5555, 16'd65535, 32'h0, 32'h0, 0, 1'b1,
      '{1'b0, KIND_TTL_EXCEEDED, 16'h0, 16'd65535, 32'h0, 32'h0}));
    // quoted protocol other than udp
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_TIME_EXCEEDED, ICMP_CODE_TTL_EXCEEDED, 5,
      8'h06, 16'h1111, 16'd33500, 32'h0A0A0A0A, 32'h0B0B0B0B, 0, 1'b1,
      '{1'b0, KIND_TTL_EXCEEDED, 16'h0, 16'h0, 32'h0, 32'h0}));
    // unknown type and code pairs
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_DEST_UNREACH, 8'd1, 5, IP_PROTO_UDP,
      16'h2222, 16'd33500, 32'h0A0A0A0A, 32'h0B0B0B0B, 0, 1'b1, '0));
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_TIME_EXCEEDED, 8'd1, 5, IP_PROTO_UDP,
      16'h2222, 16'd33500, 32'h0A0A0A0A, 32'h0B0B0B0B, 0, 1'b1, '0));
    tbl.push_back(probe_row(SHAPE_IP, 5, 8'd0, 8'd0, 5, IP_PROTO_UDP,
      16'h2222, 16'd33500, 32'h0A0A0A0A, 32'h0B0B0B0B, 0, 1'b1, '0));
    tbl.push_back(probe_row(SHAPE_IP, 5, 8'hFF, 8'hFF, 5, IP_PROTO_UDP,
      16'h2222, 16'd33500, 32'h0A0A0A0A, 32'h0B0B0B0B, 0, 1'b1, '0));
    // one byte short of the minimum, and far short
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_DEST_UNREACH, ICMP_CODE_PORT_UNREACH, 5,
      IP_PROTO_UDP, 16'h3333, 16'd33500, 32'h0A0A0A0A, 32'h0B0B0B0B, -1, 1'b1, '0));
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_TIME_EXCEEDED, ICMP_CODE_TTL_EXCEEDED, 5,
      IP_PROTO_UDP, 16'h3333, 16'd33500, 32'h0A0A0A0A, 32'h0B0B0B0B, -20, 1'b1, '0));
    // all-ones header claims 60 byte headers, all-zeros packet has type zero
    tbl.push_back(probe_row(SHAPE_FLAT_ONES, 0, 0, 0, 0, 0, 0, 0, 0, 0, 64, 1'b1, '0));
    tbl.push_back(probe_row(SHAPE_FLAT_ZERO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 20, 1'b1, '0));
    // the rest go through the predictor
    // tiny and odd header lengths: overlapping fields, bytes past the end
    tbl.push_back(probe_row(SHAPE_IP, 0, ICMP_DEST_UNREACH, ICMP_CODE_PORT_UNREACH, 0,
      IP_PROTO_UDP, 16'h4444, 16'd33450, 32'hDEADBEEF, 32'hCAFEF00D, 0, 1'b0, '0));
    tbl.push_back(probe_row(SHAPE_IP, 1, ICMP_TIME_EXCEEDED, ICMP_CODE_TTL_EXCEEDED, 2,
      IP_PROTO_UDP, 16'h4545, 16'd33460, 32'h11223344, 32'h55667788, 4, 1'b0, '0));
    tbl.push_back(probe_row(SHAPE_IP, 3, ICMP_DEST_UNREACH, ICMP_CODE_PORT_UNREACH, 4,
      IP_PROTO_UDP, 16'h4646, 16'd33470, 32'h99AABBCC, 32'hDDEEFF00, 2, 1'b0, '0));
    // largest header lengths
    tbl.push_back(probe_row(SHAPE_IP, 15, ICMP_DEST_UNREACH, ICMP_CODE_PORT_UNREACH, 15,
      IP_PROTO_UDP, 16'h4747, 16'd33500, 32'h7F000001, 32'h08080808, 0, 1'b0, '0));
    // long packets: exactly at the byte count limit and past it
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_DEST_UNREACH, ICMP_CODE_PORT_UNREACH, 5,
      IP_PROTO_UDP, 16'h4848, 16'd33480, 32'hC0000201, 32'hC6336401,
      MAX_PACKET_BYTES - 56, 1'b0, '0));
    tbl.push_back(probe_row(SHAPE_IP, 5, ICMP_TIME_EXCEEDED, ICMP_CODE_TTL_EXCEEDED, 5,
      IP_PROTO_UDP, 16'h4949, 16'd33490, 32'hC0000202, 32'hC6336402,
      MAX_PACKET_BYTES - 54, 1'b0, '0));
    // random noise
    tbl.push_back(probe_row(SHAPE_FLAT_RANDOM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 56, 1'b0, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tbl[r]) begin
      build_packet(tbl[r]);
      send_packet(tbl[r].typed, tbl[r].want);
    end

    // random phases, each with its own port window
    phase      = 0;
    rand_pkts  = 0;
    rand_bytes = 0;
    while (phase < 8 || rand_bytes < ITEM_GOAL || rand_pkts < REPLY_GOAL) begin
      settle_block();
      case (phase % 8)
        0: begin lo = 16'd0;     hi = 17'd65536; end  // every port
        1: begin lo = 16'd65535; hi = 17'd65536; end  // only the top port
        2: begin lo = 16'd0;     hi = 17'd0;     end  // empty
        3: begin lo = 16'd40000; hi = 17'd30000; end  // inverted
        4: begin lo = 16'd65535; hi = 17'd65535; end  // empty at the top
        5: begin lo = PORT_LOW_RESET; hi = PORT_HIGH_RESET; end
        default: begin
          lo   = 16'($urandom);
          span = $urandom_range(2000);
          hi   = (int'(lo) + span > 65536) ? 17'd65536 : 17'(int'(lo) + span);
        end
      endcase
      write_window(lo, hi);
      sender_bursty = (phase % 3 != 2);
      for (int k = 0; k < PKTS_PER_PHASE; k++) begin
        // mid phase the sender holds off until the block has caught up
        if (k == PKTS_PER_PHASE / 2) settle_block();
        build_packet(rand_probe());
        rand_bytes += pkt_bytes.size();
        send_packet(1'b0, '0);
        rand_pkts++;
      end
      phase++;
    end

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && reply_q.size() == 0)
      $display("icmp_error_reply_parser_top test passed");
    else
      $display("icmp_error_reply_parser_top test failed");
    $finish;
  end

  // receiver: stall pattern drawn at random from the rx modes
  initial begin : reply_pacer
    int unsigned tick;
    rx_mode_e    mode;
    out_ch.ready = 1'b0;
    tick = 0;
    mode = RX_OPEN;
    forever begin
      @(posedge clk_i);
      if (tick % 64 == 0) mode = rx_mode_e'($urandom_range(3));
      case (mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(1));
        RX_SPARSE: out_ch.ready <= (tick % 4 == 0);
        default:   out_ch.ready <= (tick % 32 > 20);  // long stalls
      endcase
      tick++;
    end
  end

  // every reply transfer against the oldest owed reply
  always @(posedge clk_i) begin : reply_check
    result_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (reply_q.size() == 0) begin
        $error("reply transfer with no reply owed");
        fail_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (out_ch.valid_res !== want.valid_res) begin
          $error("valid_res: expected %0d, got %0d", want.valid_res, out_ch.valid_res);
          fail_cnt++;
        end
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          fail_cnt++;
        end
        if (out_ch.quoted_sport !== want.quoted_sport) begin
          $error("quoted_sport: expected %0h, got %0h", want.quoted_sport,
                 out_ch.quoted_sport);
          fail_cnt++;
        end
        if (out_ch.quoted_dport !== want.quoted_dport) begin
          $error("quoted_dport: expected %0h, got %0h", want.quoted_dport,
                 out_ch.quoted_dport);
          fail_cnt++;
        end
        if (out_ch.emitter_addr !== want.emitter_addr) begin
          $error("emitter_addr: expected %0h, got %0h", want.emitter_addr,
                 out_ch.emitter_addr);
          fail_cnt++;
        end
        if (out_ch.target_addr !== want.target_addr) begin
          $error("target_addr: expected %0h, got %0h", want.target_addr,
                 out_ch.target_addr);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("icmp_error_reply_parser_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
